// File: rtl/cbtc_pkg.sv
package cbtc_pkg;

    localparam int DATA_W     = 32;
    localparam int CFG_DATA_W = 32;
    localparam int PADDR_W    = 3;
    localparam int REG_IDX_W  = 1;
    localparam int SUM_W      = 5;
    localparam int PRE_OUT_W  = 11;
    localparam int SEG1_W     = 5;
    localparam int SEG2_W     = 4;

    // Register indexes on the configuration port
    localparam logic [REG_IDX_W-1:0] REG_CLOCK_RATE = 1'b0;

    localparam logic [DATA_W-1:0] CLOCK_RATE_RESET = 32'd36000000;
    localparam int                PRESCALER_MAX    = 1024;

    localparam logic [DATA_W-1:0] MIN_BITRATE  = 32'd1000;
    localparam logic [DATA_W-1:0] FAST_BITRATE = 32'd1000000;

    // Segment sum starts one below the largest quanta count per bit
    localparam logic [SUM_W-1:0] SUM_FAST = 5'd9;
    localparam logic [SUM_W-1:0] SUM_SLOW = 5'd16;
    localparam logic [SUM_W-1:0] SUM_MIN  = 5'd2;

    localparam logic [SEG1_W-1:0] SEG1_MAX = 5'd16;
    localparam logic [SEG2_W-1:0] SEG2_MAX = 4'd8;

    localparam logic [14:0] PERMILL_FULL         = 15'd1000;
    localparam logic [14:0] SAMPLE_LIMIT_PERMILL = 15'd900;

    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] dividend;
        logic [DATA_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [DATA_W-1:0] quotient;
        logic [DATA_W-1:0] remainder;
    } div_rsp_t;

endpackage

// File: rtl/cbtc_divider.sv
module cbtc_divider
    import cbtc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int CNT_W = $clog2(DATA_W + 1);

    logic [DATA_W-1:0] quot_reg, quot_next;
    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [DATA_W-1:0] divisor_reg, divisor_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    logic [DATA_W:0]   rem_shift;
    logic [DATA_W:0]   rem_diff;
    logic              fits;

    // One quotient bit per cycle: shift the next dividend bit into the
    // partial remainder and subtract the divisor where it fits.
    always_comb
    begin
        rem_shift = {rem_reg, quot_reg[DATA_W-1]};
        rem_diff  = rem_shift - {1'b0, divisor_reg};
        fits      = rem_shift >= {1'b0, divisor_reg};

        quot_next    = quot_reg;
        rem_next     = rem_reg;
        divisor_next = divisor_reg;
        cnt_next     = cnt_reg;
        busy_next    = busy_reg;
        done_next    = 1'b0;

        if (req.start)
        begin
            quot_next    = req.dividend;
            rem_next     = '0;
            divisor_next = req.divisor;
            cnt_next     = CNT_W'(DATA_W);
            busy_next    = 1'b1;
        end
        else if (busy_reg)
        begin
            quot_next = {quot_reg[DATA_W-2:0], fits};
            rem_next  = fits ? rem_diff[DATA_W-1:0] : rem_shift[DATA_W-1:0];
            cnt_next  = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg    <= quot_next;
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
    end

    assign rsp.busy      = busy_reg;
    assign rsp.done      = done_reg;
    assign rsp.quotient  = quot_reg;
    assign rsp.remainder = rem_reg;

    // The counter only runs while a division is under way.
    assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> cnt_reg == '0 || req.start)
        else $error("divider counter left running while idle");

    // The result is flagged exactly once, in the cycle after the last step.
    assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && cnt_reg == CNT_W'(1) && !req.start |=> done_reg && !busy_reg)
        else $error("divider finished without flagging its result");

    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("divider flags a result while still busy");

endmodule

// File: rtl/cbtc_cfg.sv
module cbtc_cfg
    import cbtc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_W-1:0]    paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [DATA_W-1:0]     clock_rate
);

    logic [DATA_W-1:0]    clock_rate_reg, clock_rate_next;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign reg_idx = paddr[PADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    always_comb
    begin
        clock_rate_next = clock_rate_reg;
        if (wr_en && reg_idx == REG_CLOCK_RATE)
            clock_rate_next = pwdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clock_rate_reg <= CLOCK_RATE_RESET;
        else
            clock_rate_reg <= clock_rate_next;
    end

    always_comb
    begin
        case (reg_idx)
            REG_CLOCK_RATE: prdata = clock_rate_reg;
            default:        prdata = '0;
        endcase
    end

    assign clock_rate = clock_rate_reg;

endmodule

// File: rtl/can_bit_timing_calc_core.sv
// CAN bit timing calculator. Each target bitrate accepted on the input stream
// gives one result: the prescaler and the two time segments for the clock
// held in the clock_rate register, or an error flag in tuser with all
// fields zero. The work runs on one shared restoring divider that produces
// one quotient bit per cycle. An item needs one division for clock/bitrate,
// one to fifteen trial divisions while the quanta count is stepped down,
// and one division to verify the exact rate; bitrates below 1000 bit/s are
// rejected without any division. One item is worked on at a time; a
// finished result waits in the output register while the next bitrate is
// already accepted.
module can_bit_timing_calc_core
    import cbtc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_W-1:0]    paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [31:0]           s_tdata,  // bitrate[31:0]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [23:0]           m_tdata,  // prescaler[10:0], segment_one[15:11],
                                            // segment_two[19:16], zero[23:20]
    output logic                  m_tuser   // status[0]
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_RATIO  = 3'd1;
    localparam logic [2:0] ST_SUM    = 3'd2;
    localparam logic [2:0] ST_CHECK  = 3'd3;
    localparam logic [2:0] ST_RESULT = 3'd4;

    localparam logic [DATA_W-1:0] PRE_MAX = DATA_W'(PRESCALER_MAX);

    logic [DATA_W-1:0] clock_rate;
    div_req_t          div_req;
    div_rsp_t          div_rsp;

    logic [2:0]           state_reg, state_next;
    logic [DATA_W-1:0]    rate_reg, rate_next;
    logic [DATA_W-1:0]    ratio_reg, ratio_next;
    logic [DATA_W-1:0]    pre_reg, pre_next;
    logic [SUM_W-1:0]     sum_reg, sum_next;
    logic                 err_reg, err_next;
    logic                 div_start_reg, div_start_next;
    logic [DATA_W-1:0]    div_dividend_reg, div_dividend_next;
    logic [DATA_W-1:0]    div_divisor_reg, div_divisor_next;

    logic                 m_valid_reg, m_valid_next;
    logic                 m_err_reg, m_err_next;
    logic [PRE_OUT_W-1:0] m_pre_reg, m_pre_next;
    logic [SEG1_W-1:0]    m_seg1_reg, m_seg1_next;
    logic [SEG2_W-1:0]    m_seg2_reg, m_seg2_next;

    logic [SEG1_W-1:0]    seg1;
    logic [SUM_W-1:0]     seg2;
    logic                 segs_ok;

    // Segment 1 near 7/8 of the bit, pulled back by one step when the
    // sample point would land beyond the limit.
    function automatic logic [SEG1_W-1:0] seg1_of(input logic [SUM_W-1:0] sum);
        logic [7:0]        s7;
        logic [SEG1_W-1:0] near;
        logic [14:0]       lhs;
        logic [14:0]       rhs;
        s7   = {3'b000, sum} * 8'd7;
        near = SEG1_W'((s7 + 8'd3) >> 3);
        lhs  = PERMILL_FULL * (15'd1 + 15'(near));
        rhs  = (SAMPLE_LIMIT_PERMILL + 15'd1) * (15'd1 + 15'(sum));
        if (lhs >= rhs)
            seg1_of = SEG1_W'((s7 - 8'd1) >> 3);
        else
            seg1_of = near;
    endfunction

    cbtc_cfg u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .clock_rate (clock_rate)
    );

    assign div_req.start    = div_start_reg;
    assign div_req.dividend = div_dividend_reg;
    assign div_req.divisor  = div_divisor_reg;

    cbtc_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign seg1    = seg1_of(sum_reg);
    assign seg2    = sum_reg - SUM_W'(seg1);
    assign segs_ok = seg1 >= SEG1_W'(1) && seg1 <= SEG1_MAX &&
                     seg2 >= SUM_W'(1) && seg2 <= SUM_W'(SEG2_MAX);

    assign s_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next        = state_reg;
        rate_next         = rate_reg;
        ratio_next        = ratio_reg;
        pre_next          = pre_reg;
        sum_next          = sum_reg;
        err_next          = err_reg;
        div_start_next    = 1'b0;
        div_dividend_next = div_dividend_reg;
        div_divisor_next  = div_divisor_reg;

        m_valid_next = m_valid_reg && !m_tready;
        m_err_next   = m_err_reg;
        m_pre_next   = m_pre_reg;
        m_seg1_next  = m_seg1_reg;
        m_seg2_next  = m_seg2_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    rate_next = s_tdata;
                    sum_next  = (s_tdata >= FAST_BITRATE) ? SUM_FAST : SUM_SLOW;
                    if (s_tdata < MIN_BITRATE)
                    begin
                        err_next   = 1'b1;
                        state_next = ST_RESULT;
                    end
                    else
                    begin
                        err_next          = 1'b0;
                        div_start_next    = 1'b1;
                        div_dividend_next = clock_rate;
                        div_divisor_next  = s_tdata;
                        state_next        = ST_RATIO;
                    end
                end
            end
            ST_RATIO:
            begin
                if (div_rsp.done)
                begin
                    ratio_next        = div_rsp.quotient;
                    div_start_next    = 1'b1;
                    div_dividend_next = div_rsp.quotient;
                    div_divisor_next  = DATA_W'(sum_reg) + DATA_W'(1);
                    state_next        = ST_SUM;
                end
            end
            ST_SUM:
            begin
                if (div_rsp.done)
                begin
                    if (div_rsp.remainder == '0)
                    begin
                        pre_next = div_rsp.quotient;
                        if (div_rsp.quotient == '0 || div_rsp.quotient > PRE_MAX)
                        begin
                            err_next   = 1'b1;
                            state_next = ST_RESULT;
                        end
                        else
                        begin
                            // prescaler times quanta is the ratio itself
                            div_start_next    = 1'b1;
                            div_dividend_next = clock_rate;
                            div_divisor_next  = ratio_reg;
                            state_next        = ST_CHECK;
                        end
                    end
                    else if (sum_reg <= SUM_MIN)
                    begin
                        err_next   = 1'b1;
                        state_next = ST_RESULT;
                    end
                    else
                    begin
                        sum_next          = sum_reg - SUM_W'(1);
                        div_start_next    = 1'b1;
                        div_dividend_next = ratio_reg;
                        div_divisor_next  = DATA_W'(sum_reg);
                    end
                end
            end
            ST_CHECK:
            begin
                if (div_rsp.done)
                begin
                    err_next   = !(segs_ok && div_rsp.quotient == rate_reg);
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_err_next   = err_reg;
                    m_pre_next   = err_reg ? '0 : pre_reg[PRE_OUT_W-1:0];
                    m_seg1_next  = err_reg ? '0 : seg1;
                    m_seg2_next  = err_reg ? '0 : seg2[SEG2_W-1:0];
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            div_start_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            div_start_reg <= div_start_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rate_reg         <= rate_next;
        ratio_reg        <= ratio_next;
        pre_reg          <= pre_next;
        sum_reg          <= sum_next;
        err_reg          <= err_next;
        div_dividend_reg <= div_dividend_next;
        div_divisor_reg  <= div_divisor_next;
        m_err_reg        <= m_err_next;
        m_pre_reg        <= m_pre_next;
        m_seg1_reg       <= m_seg1_next;
        m_seg2_reg       <= m_seg2_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_err_reg;
    assign m_tdata  = {4'b0000, m_seg2_reg, m_seg1_reg, m_pre_reg};

    // A new bitrate is only taken once the divider has gone quiet.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> !div_rsp.busy && !div_start_reg)
        else $error("input accepted while a division is still running");

    // Division results only turn up while the sequencer waits for one.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> state_reg == ST_RATIO || state_reg == ST_SUM ||
                         state_reg == ST_CHECK)
        else $error("division result arrived outside a division step");

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SUM |-> sum_reg >= SUM_MIN && sum_reg <= SUM_SLOW)
        else $error("segment sum left its search range");

    // A valid timing never carries a zero field, an error carries nothing.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_pre_reg != '0 && m_seg1_reg != '0 &&
                                 m_seg2_reg != '0)
        else $error("timing result with a zero field");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("error result with non-zero fields");

endmodule
